// ----- design/mlp_forward_inference_core_macros.svh -----
// ----------------------------------------------------------------------------
// MLP forward inference core: assertion macros
// Clocked property checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_INFERENCE_CORE_MACROS_SVH
`define MLP_FORWARD_INFERENCE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge while reset is released.
`define MFI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked at every rising edge, reset included.
`define MFI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFI_ASSERT(lbl, clk, rstn, prop, msg)
`define MFI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/mfi_pkg.sv -----
// ----------------------------------------------------------------------------
// MLP forward inference package
// Sizes, field widths and the layer size clamp shared by the core.
// ----------------------------------------------------------------------------
package mfi_pkg;

    localparam int MAX_LAYERS   = 4;
    localparam int MAX_WIDTH    = 16;
    localparam int WEIGHT_DEPTH = 1024;
    localparam int BIAS_DEPTH   = MAX_LAYERS * MAX_WIDTH;
    localparam int SIZE_REGS    = 5;

    localparam int WADDR_W = $clog2(WEIGHT_DEPTH);
    localparam int BADDR_W = $clog2(BIAS_DEPTH);
    localparam int NIDX_W  = $clog2(MAX_WIDTH);
    localparam int LIDX_W  = $clog2(MAX_LAYERS);
    localparam int ACC_W   = 38;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_SIZE_INPUT  = 3'd1;
    localparam logic [2:0] REG_SIZE_FOURTH = 3'd5;
    localparam logic [2:0] REG_ACT_MODES   = 3'd6;

    // Operation codes carried in the input word's tuser.
    localparam logic OP_PARAM = 1'b0;
    localparam logic OP_ELEM  = 1'b1;

    function automatic logic [4:0] eff_size(input logic [4:0] s);
        logic [4:0] r;
        r = s;
        if (s == 5'd0) r = 5'd1;
        else if (s > 5'(MAX_WIDTH)) r = 5'(MAX_WIDTH);
        return r;
    endfunction

endpackage

// ----- design/mlp_forward_inference_core.sv -----
// ----------------------------------------------------------------------------
// MLP forward inference core
// Dense Q4.12 perceptron with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes words of two kinds, selected by s_tuser. A
// parameter word writes one weight or bias at a flat address (weights first,
// layer by layer, then biases). An element word stores one
// input value; s_tlast marks the end of the vector. The last element starts the
// forward pass, during which s_tready is low. Each neuron sums its inputs one
// after another through the single multiplier and accumulator. Results then
// leave on m_ one word at a time, each held until m_tready takes it; m_tlast
// marks the last neuron and m_tuser flags a wrong input length. A stalled
// receiver simply holds the core in its output phase. Configuration is
// written through cfg_wr_en / cfg_index / cfg_data; the user must write it
// only while the core is idle, as the block itself does not enforce this.
// Reset restores the register defaults and clears the element count; the
// parameter and value memories keep their contents and are not cleared.
// ----------------------------------------------------------------------------
`include "mlp_forward_inference_core_macros.svh"

module mlp_forward_inference_core
    import mfi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // param_address [10:0], param_value [26:11], in_value [42:27], zero above
    input  logic [47:0] s_tdata,
    // operation
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_value [15:0]
    output logic [15:0] m_tdata,
    // count_error
    output logic        m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DRAIN, S_ACT1, S_ACT2, S_ORD, S_OWAIT, S_OUT
    } state_t;

    // Configuration registers.
    logic [2:0] layer_count_reg;
    logic [4:0] size_reg [SIZE_REGS];
    logic [3:0] act_modes_reg;

    // Memories.
    logic [15:0] weight_mem [WEIGHT_DEPTH];
    logic [15:0] bias_mem [BIAS_DEPTH];
    logic [15:0] lv_mem [2*MAX_WIDTH];
    logic [15:0] w_q, b_q, lv_q;

    // Sequencer state.
    state_t              state_reg, state_next;
    logic [4:0]          ecount_reg, ecount_next;
    logic [4:0]          ecnt_fin_reg, ecnt_fin_next;
    logic                err_reg, err_next;
    logic [LIDX_W-1:0]   layer_reg, layer_next;
    logic [NIDX_W-1:0]   o_reg, o_next;
    logic [NIDX_W-1:0]   i_reg, i_next;
    logic [WADDR_W-1:0]  wptr_reg, wptr_next;
    logic [BADDR_W-1:0]  bptr_reg, bptr_next;
    logic                bank_reg, bank_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // MAC pipeline.
    logic                p1_valid_reg, p1_mask_reg, p1_first_reg, p1_last_reg;
    logic                p2_valid_reg, p2_first_reg, p2_last_reg;
    logic signed [31:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]  sat_reg;

    logic [4:0]  eff_sz [SIZE_REGS];
    logic [2:0]  nl;
    logic [4:0]  ic, nout;
    logic [10:0] wtot;
    logic [6:0]  btot;
    logic [10:0] paddr, boffs;
    logic        issue;
    logic        lv_we;
    logic [NIDX_W:0]   lv_waddr, lv_raddr;
    logic [15:0] lv_wdata;
    logic [15:0] act_val;
    logic        accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = err_reg;
    assign paddr    = s_tdata[10:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= 3'd1;
            for (int k = 0; k < SIZE_REGS; k++) size_reg[k] <= 5'(MAX_WIDTH);
            act_modes_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_LAYER_COUNT) layer_count_reg <= cfg_data[2:0];
            else if (cfg_index >= REG_SIZE_INPUT && cfg_index <= REG_SIZE_FOURTH)
                size_reg[cfg_index - REG_SIZE_INPUT] <= cfg_data;
            else if (cfg_index == REG_ACT_MODES) act_modes_reg <= cfg_data[3:0];
        end
    end

    // Layout of the parameter space follows the configured sizes.
    always_comb begin
        for (int k = 0; k < SIZE_REGS; k++) eff_sz[k] = eff_size(size_reg[k]);
        nl = layer_count_reg;
        if (nl == 3'd0) nl = 3'd1;
        else if (nl > 3'(MAX_LAYERS)) nl = 3'(MAX_LAYERS);
        wtot = '0;
        btot = '0;
        for (int l = 0; l < MAX_LAYERS; l++) begin
            if (3'(l) < nl) begin
                wtot = wtot + 11'(eff_sz[l] * eff_sz[l+1]);
                btot = btot + 7'(eff_sz[l+1]);
            end
        end
        ic   = eff_sz[layer_reg];
        nout = eff_sz[3'(layer_reg) + 3'd1];
        boffs = paddr - wtot;
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == OP_PARAM) begin
            if (paddr < wtot) begin
                if (paddr < 11'(WEIGHT_DEPTH)) weight_mem[paddr[WADDR_W-1:0]] <= s_tdata[26:11];
            end else if (boffs < 11'(btot)) begin
                bias_mem[boffs[BADDR_W-1:0]] <= s_tdata[26:11];
            end
        end
        w_q <= weight_mem[wptr_reg];
        b_q <= bias_mem[bptr_reg];
    end

    // Value store: input vector in bank 0, layers ping-pong between banks.
    always_comb begin
        lv_we    = 1'b0;
        lv_waddr = {1'b0, ecount_reg[NIDX_W-1:0]};
        lv_wdata = s_tdata[42:27];
        if (state_reg == S_ACT2) begin
            lv_we    = 1'b1;
            lv_waddr = {~bank_reg, o_reg};
            lv_wdata = act_val;
        end else if (accept && s_tuser == OP_ELEM && ecount_reg < eff_sz[0]) begin
            lv_we = 1'b1;
        end
        lv_raddr = (state_reg == S_MAC) ? {bank_reg, i_reg} : {bank_reg, o_reg};
    end

    always_ff @(posedge aclk) begin
        if (lv_we) lv_mem[lv_waddr] <= lv_wdata;
        lv_q <= lv_mem[lv_raddr];
    end

    // Activation on the saturated neuron sum.
    always_comb begin
        logic [16:0] a;
        logic [12:0] y;
        a = sat_reg[15] ? 17'(-{sat_reg[15], sat_reg}) : {1'b0, sat_reg};
        if (a >= 17'd20480)     y = 13'd4096;
        else if (a >= 17'd9728) y = 13'(a >> 5) + 13'd3456;
        else if (a >= 17'd4096) y = 13'(a >> 3) + 13'd2560;
        else                    y = 13'(a >> 2) + 13'd2048;
        if (act_modes_reg[layer_reg])
            act_val = sat_reg[15] ? 16'(13'd4096 - y) : {3'b000, y};
        else
            act_val = sat_reg[15] ? 16'd0 : sat_reg;
    end

    assign issue = (state_reg == S_MAC);

    // Multiply, then accumulate with the bias on the first product.
    always_ff @(posedge aclk) begin
        logic signed [ACC_W-1:0] base;
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-13:0] r;
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
        p1_mask_reg  <= (layer_reg == '0) && ({1'b0, i_reg} >= ecnt_fin_reg);
        p1_first_reg <= (i_reg == '0);
        p1_last_reg  <= ({1'b0, i_reg} == ic - 5'd1);
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        prod_reg <= p1_mask_reg ? 32'sd0 : $signed(w_q) * $signed(lv_q);
        base = p2_first_reg ? ACC_W'($signed({b_q, 12'd0})) : acc_reg;
        if (p2_valid_reg) acc_reg <= base + ACC_W'(prod_reg);
        rnd = acc_reg + ACC_W'(2048);
        r   = rnd[ACC_W-1:12];
        if (r > 26'sd32767)       sat_reg <= 16'sh7FFF;
        else if (r < -26'sd32768) sat_reg <= 16'sh8000;
        else                      sat_reg <= r[15:0];
    end

    always_comb begin
        logic [4:0] cnt;
        state_next    = state_reg;
        ecount_next   = ecount_reg;
        ecnt_fin_next = ecnt_fin_reg;
        err_next      = err_reg;
        layer_next    = layer_reg;
        o_next        = o_reg;
        i_next        = i_reg;
        wptr_next     = wptr_reg;
        bptr_next     = bptr_reg;
        bank_next     = bank_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        cnt = (ecount_reg == 5'd31) ? ecount_reg : ecount_reg + 5'd1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_tuser == OP_ELEM) begin
                    ecount_next = cnt;
                    if (s_tlast) begin
                        ecount_next   = '0;
                        ecnt_fin_next = cnt;
                        err_next      = (cnt != eff_sz[0]);
                        layer_next    = '0;
                        o_next        = '0;
                        i_next        = '0;
                        wptr_next     = '0;
                        bptr_next     = '0;
                        bank_next     = 1'b0;
                        state_next    = S_MAC;
                    end
                end
            end
            S_MAC: begin
                wptr_next = wptr_reg + 1'b1;
                if ({1'b0, i_reg} == ic - 5'd1) state_next = S_DRAIN;
                else i_next = i_reg + 1'b1;
            end
            S_DRAIN: begin
                if (p2_valid_reg && p2_last_reg) state_next = S_ACT1;
            end
            S_ACT1: state_next = S_ACT2;
            S_ACT2: begin
                i_next    = '0;
                bptr_next = bptr_reg + 1'b1;
                state_next = S_MAC;
                if ({1'b0, o_reg} == nout - 5'd1) begin
                    o_next    = '0;
                    bank_next = ~bank_reg;
                    if (3'(layer_reg) == nl - 3'd1) state_next = S_ORD;
                    else layer_next = layer_reg + 1'b1;
                end else begin
                    o_next = o_reg + 1'b1;
                end
            end
            S_ORD: state_next = S_OWAIT;
            S_OWAIT: begin
                m_valid_next = 1'b1;
                m_data_next  = lv_q;
                m_last_next  = ({1'b0, o_reg} == nout - 5'd1);
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) state_next = S_IDLE;
                    else begin
                        o_next     = o_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ecount_reg  <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            layer_reg   <= '0;
            o_reg       <= '0;
            i_reg       <= '0;
            bank_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ecount_reg  <= ecount_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
            layer_reg   <= layer_next;
            o_reg       <= o_next;
            i_reg       <= i_next;
            bank_reg    <= bank_next;
        end
        ecnt_fin_reg <= ecnt_fin_next;
        wptr_reg     <= wptr_next;
        bptr_reg     <= bptr_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    `MFI_ASSERT(a_no_accept_while_out, aclk, aresetn, m_valid_reg |-> !s_tready, "input taken during output")
    `MFI_ASSERT(a_last_starts_pass, aclk, aresetn, (accept && s_tuser == OP_ELEM && s_tlast) |=> (state_reg == S_MAC), "pass did not start")
    `MFI_ASSERT(a_mac_only_busy, aclk, aresetn, p2_valid_reg |-> (state_reg == S_MAC || state_reg == S_DRAIN), "product outside accumulation")
    `MFI_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg), "reset did not idle")

endmodule
